// ===== rtl/vcsg_pkg.sv =====
// shared types, constants and tables of the vector character stroke generator
// stroke rom, glyph directory, scaling and saturation helpers
// no dependencies
package vcsg_pkg;

  localparam int STROKE_ROM_DEPTH       = 1024;
  localparam int MAX_SEGMENTS_PER_GLYPH = 10;
  localparam int COORD_FRAC_BITS        = 4;

  localparam int COORD_W   = 18;
  localparam int SCALE_W   = 12;
  localparam int CODE_W    = 8;
  localparam int HALF_W    = 5;
  localparam int ADDR_W    = $clog2(STROKE_ROM_DEPTH);
  localparam int CNT_W     = $clog2(MAX_SEGMENTS_PER_GLYPH + 1);
  localparam int DIR_CNT_W = 4;
  localparam int DIR_ST_W  = 8;
  localparam int RND_W     = 18 + COORD_FRAC_BITS;
  localparam int OFF_W     = RND_W - 9;
  localparam int SUM_W     = COORD_W + 2;

  localparam int ROM_LEN   = 183;
  localparam int ROM_IDX_W = $clog2(ROM_LEN);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);
  localparam logic [HALF_W-1:0]  ADVANCE_HALF_UNITS = HALF_W'(19);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t              pen_x;
    coord_t              pen_y;
    coord_t              next_x;
    logic [ADDR_W-1:0]   start;
    logic [CNT_W-1:0]    count;
  } job_t;

  typedef struct packed {
    logic [DIR_ST_W-1:0]  start;
    logic [DIR_CNT_W-1:0] count;
  } dir_t;

  // rows hold x0, y0, x1, y1 from the high nibble down, in half units
  localparam logic [15:0] STROKE_ROM [0:ROM_LEN-1] = '{
    16'h747C, 16'h7072,
    16'h00EC, 16'h2C2A, 16'hC0C2,
    16'h7C7A,
    16'h4020, 16'h2002, 16'h020A, 16'h0A2C, 16'h2C4C,
    16'hA0C0, 16'hC0E2, 16'hE2EA, 16'hEACC, 16'hCCAC,
    16'h26C6,
    16'h6080,
    16'h0EE0,
    16'h00E0, 16'hE0EC, 16'hEC0C, 16'h0C00,
    16'h707C,
    16'hE000, 16'h0006, 16'h06E6, 16'hE6EC, 16'hEC0C,
    16'h00E0, 16'hE0E6, 16'hE686, 16'h86EC, 16'hEC0C,
    16'hA0AC, 16'hAC06, 16'h06E6,
    16'h060C, 16'h0CEC, 16'h06E6, 16'h00E0, 16'hE0E6,
    16'h000C, 16'h0CEC, 16'h06E6, 16'h00E0, 16'hE0E6,
    16'h40EC, 16'hEC0C,
    16'h000C, 16'h0CEC, 16'h06E6, 16'h00E0, 16'hE0EC,
    16'h00E0, 16'hE0EC, 16'hEC0C, 16'h0C06, 16'h06E6,
    16'h06E0, 16'hE0EE, 16'hEE06,
    16'h00E6, 16'hE60E, 16'h0E00,
    16'h0CEC, 16'hECE6, 16'hE646, 16'h4644, 16'h4042,
    16'h20C0,
    16'h007C, 16'h7CE0, 16'hE000,
    16'h0C70, 16'h70EC, 16'h0CEC,
    16'h000C, 16'h0CE7, 16'hE700,
    16'h07E0, 16'hECE0, 16'hEC07,
    16'h00E0, 16'hE0EC, 16'hEC0C, 16'h0C00, 16'h22A2, 16'hAA2A, 16'h2A22,
    16'h0006, 16'h0CEC, 16'h06E6, 16'h00E0, 16'hE0EC,
    16'h000C, 16'h0CCC, 16'hCCEA, 16'hEAE8, 16'hE8C6,
    16'hC606, 16'h00C0, 16'hC0E2, 16'hE2E4, 16'hE4C6,
    16'h00E0, 16'hEC0C, 16'h0C00,
    16'h000C, 16'h0CCC, 16'hCCEA, 16'hEAE2, 16'hE2C0, 16'hC000,
    16'h000C, 16'h0CEC, 16'hECE6, 16'hE606, 16'h00E0,
    16'h000C, 16'h0CEC, 16'h0686,
    16'h000C, 16'h06E6, 16'hE0EC,
    16'h707C,
    16'h0220, 16'h20C0, 16'hC0E2, 16'hE2EC,
    16'h000C, 16'h04EC, 16'h68E0,
    16'h00E0, 16'h0C00,
    16'h000C, 16'h0C6C, 16'h6C8A, 16'h8A80, 16'h8ACC, 16'hCCEC, 16'hECE0,
    16'h000C, 16'h084C, 16'h4CEC, 16'hECE0,
    16'h000C, 16'h0CEC, 16'hECE6, 16'hE606,
    16'h000C, 16'h0CEC, 16'hECE4, 16'hE4C0, 16'hC000, 16'hA4E0,
    16'h000C, 16'h084C, 16'h4CEC,
    16'h00E0, 16'hE0E6, 16'hE606, 16'h060C, 16'h0CEC,
    16'h707C, 16'h0CEC,
    16'h00E0, 16'hE0EC, 16'h0C00,
    16'h0C70, 16'h70EC,
    16'h0C00, 16'h0076, 16'h76E0, 16'hE0EC,
    16'h00EC, 16'h0CE0,
    16'h0C76, 16'h7670, 16'h76EC,
    16'h0CEC, 16'hEC00, 16'h00E0
  };

  function automatic logic [15:0] rom_row(input logic [ROM_IDX_W-1:0] idx);
    logic [15:0] row;
    row = 16'h0000;
    if (idx < ROM_IDX_W'(ROM_LEN)) begin
      row = STROKE_ROM[idx];
    end
    return row;
  endfunction

  function automatic dir_t glyph_dir(input logic [CODE_W-1:0] code_in);
    logic [CODE_W-1:0] code;
    dir_t d;
    code = code_in;
    if (code inside {[8'd97:8'd122]}) begin
      code = code - 8'd32;
    end
    case (code)
      8'd33:               d = '{8'd0,   4'd2};
      8'd37:               d = '{8'd2,   4'd3};
      8'd39, 8'd44:        d = '{8'd5,   4'd1};
      8'd40, 8'd91, 8'd123: d = '{8'd6,  4'd5};
      8'd41, 8'd93, 8'd125: d = '{8'd11, 4'd5};
      8'd45:               d = '{8'd16,  4'd1};
      8'd46:               d = '{8'd17,  4'd1};
      8'd47:               d = '{8'd18,  4'd1};
      8'd48, 8'd79:        d = '{8'd19,  4'd4};
      8'd49:               d = '{8'd23,  4'd1};
      8'd50:               d = '{8'd24,  4'd5};
      8'd51:               d = '{8'd29,  4'd5};
      8'd52:               d = '{8'd34,  4'd3};
      8'd53:               d = '{8'd37,  4'd5};
      8'd54, 8'd71:        d = '{8'd42,  4'd5};
      8'd55:               d = '{8'd47,  4'd2};
      8'd56:               d = '{8'd49,  4'd5};
      8'd57:               d = '{8'd54,  4'd5};
      8'd60:               d = '{8'd59,  4'd3};
      8'd62:               d = '{8'd62,  4'd3};
      8'd63:               d = '{8'd65,  4'd5};
      8'd95:               d = '{8'd70,  4'd1};
      8'd128:              d = '{8'd71,  4'd3};
      8'd129:              d = '{8'd74,  4'd3};
      8'd130:              d = '{8'd77,  4'd3};
      8'd131:              d = '{8'd80,  4'd3};
      8'd132:              d = '{8'd83,  4'd7};
      8'd65:               d = '{8'd90,  4'd5};
      8'd66:               d = '{8'd95,  4'd10};
      8'd67:               d = '{8'd105, 4'd3};
      8'd68:               d = '{8'd108, 4'd6};
      8'd69:               d = '{8'd114, 4'd5};
      8'd70:               d = '{8'd119, 4'd3};
      8'd72:               d = '{8'd122, 4'd3};
      8'd73:               d = '{8'd125, 4'd1};
      8'd74:               d = '{8'd126, 4'd4};
      8'd75:               d = '{8'd130, 4'd3};
      8'd76:               d = '{8'd133, 4'd2};
      8'd77:               d = '{8'd135, 4'd7};
      8'd78:               d = '{8'd142, 4'd4};
      8'd80:               d = '{8'd146, 4'd4};
      8'd81:               d = '{8'd150, 4'd6};
      8'd82:               d = '{8'd156, 4'd3};
      8'd83:               d = '{8'd159, 4'd5};
      8'd84:               d = '{8'd164, 4'd2};
      8'd85:               d = '{8'd166, 4'd3};
      8'd86:               d = '{8'd169, 4'd2};
      8'd87:               d = '{8'd171, 4'd4};
      8'd88:               d = '{8'd175, 4'd2};
      8'd89:               d = '{8'd177, 4'd3};
      8'd90:               d = '{8'd180, 4'd3};
      default:             d = '{8'd0,   4'd0};
    endcase
    return d;
  endfunction

  // (h * scale * 2^frac + 256) >> 9, always non-negative
  function automatic logic [OFF_W-1:0] scale_off(input logic [HALF_W-1:0] h,
                                                 input logic [SCALE_W-1:0] s);
    logic [RND_W-1:0] p;
    p = (RND_W'(h) * RND_W'(s)) << COORD_FRAC_BITS;
    p = p + RND_W'(256);
    return OFF_W'(p >> 9);
  endfunction

  function automatic coord_t pen_add(input coord_t pen, input logic [OFF_W-1:0] off);
    logic signed [SUM_W-1:0] v;
    coord_t r;
    v = SUM_W'(pen) + $signed(SUM_W'(off));
    if (v > SUM_W'(131071)) begin
      r = 18'sh1FFFF;
    end else if (v < -SUM_W'(131072)) begin
      r = 18'sh20000;
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== rtl/vcsg_front.sv =====
// front end: takes character transactions, tracks the pen and looks up glyphs
// emits one job per character into the queue
// depends on vcsg_pkg
module vcsg_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [vcsg_pkg::CODE_W-1:0]  char_code,
  input  logic                         new_string,
  input  vcsg_pkg::coord_t             start_x,
  input  vcsg_pkg::coord_t             start_y,
  input  logic [vcsg_pkg::SCALE_W-1:0] scale,
  output logic                         push_valid,
  input  logic                         push_ready,
  output vcsg_pkg::job_t               push_data
);
  import vcsg_pkg::*;

  coord_t            pen_x;
  coord_t            pen_y;
  coord_t            cur_x;
  coord_t            cur_y;
  coord_t            adv_x;
  dir_t              dir;
  logic [CNT_W-1:0]  cnt;

  always_comb begin
    cur_x = new_string ? start_x : pen_x;
    cur_y = new_string ? start_y : pen_y;
    adv_x = pen_add(cur_x, scale_off(ADVANCE_HALF_UNITS, scale));
    dir   = glyph_dir(char_code);
    if (5'(dir.count) > 5'(MAX_SEGMENTS_PER_GLYPH)) begin
      cnt = CNT_W'(MAX_SEGMENTS_PER_GLYPH);
    end else begin
      cnt = CNT_W'(dir.count);
    end
  end

  assign s_ready    = push_ready;
  assign push_valid = s_valid;

  always_comb begin
    push_data.pen_x  = cur_x;
    push_data.pen_y  = cur_y;
    push_data.next_x = adv_x;
    push_data.start  = ADDR_W'(dir.start);
    push_data.count  = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x <= '0;
      pen_y <= '0;
    end else if (s_valid && push_ready) begin
      pen_x <= adv_x;
      pen_y <= cur_y;
    end
  end

endmodule

// ===== rtl/vcsg_queue.sv =====
// short job queue between the front end and the stroke walker
// depends on vcsg_pkg
module vcsg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  vcsg_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output vcsg_pkg::job_t pop_data
);
  import vcsg_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (!do_push && do_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/vcsg_back.sv =====
// back end: walks the strokes of one job, scales and offsets each endpoint
// drives the registered result stream; depends on vcsg_pkg
module vcsg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [vcsg_pkg::SCALE_W-1:0] scale,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  vcsg_pkg::job_t               job,
  output logic                         m_valid,
  input  logic                         m_ready,
  output vcsg_pkg::coord_t             seg_x0,
  output vcsg_pkg::coord_t             seg_y0,
  output vcsg_pkg::coord_t             seg_x1,
  output vcsg_pkg::coord_t             seg_y1,
  output logic                         has_segment,
  output logic                         last_of_char,
  output vcsg_pkg::coord_t             next_pen_x
);
  import vcsg_pkg::*;

  logic [CNT_W-1:0]  k;
  logic [ADDR_W-1:0] addr;
  logic [15:0]       row;
  logic              blank;
  logic              is_last;
  logic              load;
  coord_t            x0;
  coord_t            y0;
  coord_t            x1;
  coord_t            y1;

  always_comb begin
    addr    = job.start + ADDR_W'(k);
    row     = rom_row(addr[ROM_IDX_W-1:0]);
    blank   = (job.count == '0);
    is_last = blank || (k == CNT_W'(job.count - 1'b1));
    x0 = pen_add(job.pen_x, scale_off(HALF_W'(row[15:12]), scale));
    y0 = pen_add(job.pen_y, scale_off(HALF_W'(row[11:8]), scale));
    x1 = pen_add(job.pen_x, scale_off(HALF_W'(row[7:4]), scale));
    y1 = pen_add(job.pen_y, scale_off(HALF_W'(row[3:0]), scale));
  end

  assign load      = !m_valid || m_ready;
  assign job_ready = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      k       <= '0;
    end else if (load) begin
      m_valid <= job_valid;
      if (job_valid) begin
        k <= is_last ? '0 : k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      seg_x0       <= blank ? '0 : x0;
      seg_y0       <= blank ? '0 : y0;
      seg_x1       <= blank ? '0 : x1;
      seg_y1       <= blank ? '0 : y1;
      has_segment  <= !blank;
      last_of_char <= is_last;
      next_pen_x   <= is_last ? job.next_x : '0;
    end
  end

endmodule

// ===== rtl/vector_char_stroke_generator.sv =====
// Vector stroke character generator. Each input transaction names one character;
// the block answers with one result transaction per line segment of its glyph
// (tlast on the final one, which also carries the advanced pen x), or a single
// result without a segment for codes that have no glyph. Results leave at one per
// cycle from an output register while m_axis_tready allows, up to 10 segments per
// character, paced by the stroke walker that reads one stroke rom row per cycle
// unless the output stalls. A two-entry job queue lets new characters be taken while
// a glyph is still being drawn. The scale register is written over the cfg channel.
module vector_char_stroke_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vcsg_pkg::SCALE_W-1:0] cfg_data,       // scale_q4_8
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [47:0]                  s_axis_tdata,   // char_code, start_x, start_y
  input  logic                         s_axis_tuser,   // new_string
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [95:0]                  m_axis_tdata,   // seg_x0, seg_y0, seg_x1, seg_y1, next_pen_x
  output logic                         m_axis_tuser,   // has_segment
  output logic                         m_axis_tlast    // last_of_char
);
  import vcsg_pkg::*;

  logic [SCALE_W-1:0] scale_q4_8;
  logic               push_valid;
  logic               push_ready;
  job_t               push_data;
  logic               job_valid;
  logic               job_ready;
  job_t               job;
  coord_t             seg_x0;
  coord_t             seg_y0;
  coord_t             seg_x1;
  coord_t             seg_y1;
  coord_t             next_pen_x;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_q4_8 <= SCALE_RESET;
    end else if (cfg_valid) begin
      scale_q4_8 <= cfg_data;
    end
  end

  vcsg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .char_code  (s_axis_tdata[7:0]),
    .new_string (s_axis_tuser),
    .start_x    ($signed(s_axis_tdata[25:8])),
    .start_y    ($signed(s_axis_tdata[43:26])),
    .scale      (scale_q4_8),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  vcsg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (job_valid),
    .pop_ready  (job_ready),
    .pop_data   (job)
  );

  vcsg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .scale        (scale_q4_8),
    .job_valid    (job_valid),
    .job_ready    (job_ready),
    .job          (job),
    .m_valid      (m_axis_tvalid),
    .m_ready      (m_axis_tready),
    .seg_x0       (seg_x0),
    .seg_y0       (seg_y0),
    .seg_x1       (seg_x1),
    .seg_y1       (seg_y1),
    .has_segment  (m_axis_tuser),
    .last_of_char (m_axis_tlast),
    .next_pen_x   (next_pen_x)
  );

  assign m_axis_tdata = {6'b0, next_pen_x, seg_y1, seg_x1, seg_y0, seg_x0};

endmodule
